// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/lcst_pkg.sv
// Types and helpers for the Li Chao segment max tree.
// No dependencies.
`default_nettype none
package lcst_pkg;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [63:0] intercept;
	} line_t;

	function automatic logic above(input logic signed [63:0] a, input logic signed [63:0] b);
		return a > b;
	endfunction

endpackage
`default_nettype wire

// File: rtl/li_chao_segment_max_tree.sv
// Li Chao segment max tree, top level.
// Depends on lcst_pkg and assert_macros.svh.
//
// Usage:
//  A command beat is taken at a rising edge with start high and busy low.
//  operation 0 inserts the line (slope, intercept) on [range_start, range_end),
//  clamped to [0, POINTS); operation 1 queries the maximum at point.
//  A query returns one result: max_value with valid high for one cycle, on the
//  cycle busy drops. An insert returns nothing. The receiver cannot stall.
//  A query reads, evaluates and compares the node at each tree level, leaf to root;
//  T is POINTS rounded up to a power of two. An insert walks the levels of the
//  covering split and, from each covering node, takes at most one descent step
//  per level below it; the node memory's single read port and the shared
//  multiplier serialize these steps.
//  After reset the node memory is cleared, one entry a cycle, all 2*T entries,
//  with busy high.
`default_nettype none
`include "assert_macros.svh"
module li_chao_segment_max_tree #(
	parameter int POINTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic               operation,
	input  wire logic signed [11:0] range_start,
	input  wire logic signed [11:0] range_end,
	input  wire logic signed [31:0] slope,
	input  wire logic signed [63:0] intercept,
	input  wire logic        [9:0]  point,
	output      logic               valid,
	output      logic        [62:0] max_value
);
	import lcst_pkg::*;

	localparam int T  = (POINTS <= 2) ? 2 : 2 ** $clog2(POINTS);
	localparam int LW = $clog2(T) + 1;
	localparam int CW = LW + 1;
	localparam int HW = $clog2(LW + 1);
	localparam int PW = 33 + LW;
	localparam int DEPTH = 2 * T;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_CLR  = 5'd1;
	localparam logic [4:0] ST_CL   = 5'd2;
	localparam logic [4:0] ST_CR   = 5'd3;
	localparam logic [4:0] ST_CSH  = 5'd4;
	localparam logic [4:0] ST_RD   = 5'd5;
	localparam logic [4:0] ST_M1   = 5'd6;
	localparam logic [4:0] ST_M2   = 5'd7;
	localparam logic [4:0] ST_SW   = 5'd8;
	localparam logic [4:0] ST_L1   = 5'd9;
	localparam logic [4:0] ST_L2   = 5'd10;
	localparam logic [4:0] ST_L3   = 5'd11;
	localparam logic [4:0] ST_H2   = 5'd12;
	localparam logic [4:0] ST_H3   = 5'd13;
	localparam logic [4:0] ST_QRD  = 5'd14;
	localparam logic [4:0] ST_QEV  = 5'd15;
	localparam logic [4:0] ST_QCMP = 5'd16;

	logic [4:0]  state_q;
	logic [LW-1:0] clr_q;
	logic [CW-1:0] l_q, r_q;
	logic [HW-1:0] h_q;
	logic          ret_q;
	logic [LW-1:0] u_q;
	logic [LW-1:0] lo_q, hi_q;
	line_t         ins_q, cur_q, nd_q;
	logic signed [63:0] ev_q, v_q, best_q;
	logic [LW-1:0] qx_q, qi_q;
	logic          oob_q;
	logic          valid_q;

	line_t         mem [DEPTH];
	line_t         rd_q;
	logic          we;
	logic [LW-1:0] wa, ra;
	line_t         wd;

	logic signed [31:0] a_w, b_w, a_c, b_c;
	logic [LW-1:0] mid;
	logic [LW-1:0] n_lo, n_hi, node_n;
	logic [CW-1:0] node_c;
	line_t         sel_line;
	logic [LW-1:0] sel_x;
	logic signed [PW-1:0] prod;
	logic signed [63:0]   ev_n;
	logic          swap;

	function automatic logic [LW-1:0] span_lo(input logic [CW-1:0] n, input logic [HW-1:0] h);
		logic [CW-1:0] t;
		t = (n << h) - CW'(T);
		return t[LW-1:0];
	endfunction

	assign a_w = 32'(range_start);
	assign b_w = 32'(range_end);
	assign a_c = (a_w < 0) ? 32'sd0 : a_w;
	assign b_c = (b_w > POINTS) ? 32'(POINTS) : b_w;

	assign mid  = LW'((CW'(lo_q) + CW'(hi_q)) >> 1);
	assign node_c = (state_q == ST_CL) ? l_q : (r_q - CW'(1));
	assign node_n = node_c[LW-1:0];
	assign n_lo = span_lo(node_c, h_q);
	assign n_hi = span_lo(node_c + CW'(1), h_q);

	always_comb begin
		sel_line = cur_q;
		sel_x    = mid;
		case (state_q)
			ST_M2:  begin sel_line = nd_q; sel_x = mid;  end
			ST_L1:  begin sel_line = cur_q; sel_x = lo_q; end
			ST_L2:  begin sel_line = nd_q; sel_x = lo_q; end
			ST_L3:  begin sel_line = cur_q; sel_x = hi_q; end
			ST_H2:  begin sel_line = nd_q; sel_x = hi_q; end
			ST_QEV: begin sel_line = rd_q; sel_x = qx_q; end
			default: begin sel_line = cur_q; sel_x = mid; end
		endcase
	end

	assign prod = sel_line.slope * $signed({1'b0, sel_x});
	assign ev_n = {{(64 - PW){prod[PW-1]}}, prod} + sel_line.intercept;
	assign swap = above(v_q, ev_q);

	always_comb begin
		we = 1'b0;
		wa = u_q;
		wd = cur_q;
		ra = (state_q == ST_QRD) ? qi_q : u_q;
		if (state_q == ST_CLR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (state_q == ST_SW && swap) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		ev_q <= ev_n;
		if (state_q == ST_M2 || state_q == ST_L2 || state_q == ST_H2)
			v_q <= ev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			valid_q <= 1'b0;
			l_q     <= '0;
			r_q     <= '0;
			h_q     <= '0;
			ret_q   <= 1'b0;
			u_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			ins_q   <= '0;
			cur_q   <= '0;
			nd_q    <= '0;
			best_q  <= '0;
			qx_q    <= '0;
			qi_q    <= '0;
			oob_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == LW'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						if (operation) begin
							best_q <= '0;
							qx_q   <= LW'(point);
							oob_q  <= (32'(point) >= POINTS);
							qi_q   <= (32'(point) >= POINTS) ? LW'(1) : LW'(point) + LW'(T);
							state_q <= ST_QRD;
						end else begin
							ins_q.slope     <= slope;
							ins_q.intercept <= intercept;
							h_q <= '0;
							if (a_c < b_c) begin
								l_q <= CW'(a_c) + CW'(T);
								r_q <= CW'(b_c) + CW'(T);
							end else begin
								l_q <= '0;
								r_q <= '0;
							end
							state_q <= ST_CL;
						end
					end
				end
				ST_CL: begin
					if (l_q < r_q) begin
						if (l_q[0]) begin
							u_q   <= node_n;
							lo_q  <= n_lo;
							hi_q  <= n_hi;
							cur_q <= ins_q;
							ret_q <= 1'b0;
							l_q   <= l_q + CW'(1);
							state_q <= ST_RD;
						end else begin
							state_q <= ST_CR;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CR: begin
					if (r_q[0]) begin
						u_q   <= node_n;
						lo_q  <= n_lo;
						hi_q  <= n_hi;
						cur_q <= ins_q;
						ret_q <= 1'b1;
						r_q   <= r_q - CW'(1);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_CSH;
					end
				end
				ST_CSH: begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
					h_q <= h_q + HW'(1);
					state_q <= ST_CL;
				end
				ST_RD: state_q <= ST_M1;
				ST_M1: begin
					nd_q <= rd_q;
					state_q <= ST_M2;
				end
				ST_M2: state_q <= ST_SW;
				ST_SW: begin
					if (swap) begin
						nd_q  <= cur_q;
						cur_q <= nd_q;
					end
					if (CW'(lo_q) + CW'(1) >= CW'(hi_q))
						state_q <= ret_q ? ST_CSH : ST_CR;
					else
						state_q <= ST_L1;
				end
				ST_L1: state_q <= ST_L2;
				ST_L2: state_q <= ST_L3;
				ST_L3: begin
					if (swap) begin
						u_q  <= LW'({u_q, 1'b0});
						hi_q <= mid;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_H2;
					end
				end
				ST_H2: state_q <= ST_H3;
				ST_H3: begin
					if (swap) begin
						u_q  <= LW'({u_q, 1'b1});
						lo_q <= mid;
						state_q <= ST_RD;
					end else begin
						state_q <= ret_q ? ST_CSH : ST_CR;
					end
				end
				ST_QRD: state_q <= ST_QEV;
				ST_QEV: state_q <= ST_QCMP;
				ST_QCMP: begin
					if (!oob_q && above(ev_q, best_q))
						best_q <= ev_q;
					if (qi_q == LW'(1)) begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						qi_q <= qi_q >> 1;
						state_q <= ST_QRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign valid     = valid_q;
	assign max_value = best_q[62:0];

	`ASSERT_ALWAYS(a_valid_idle, clk, valid |-> !busy, "result while busy")
	`ASSERT_CLK(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accepted beat left block idle")
	`ASSERT_CLK(a_valid_pulse, clk, arst_n, valid |=> !valid, "result strobe longer than one cycle")
	`ASSERT_ALWAYS(a_write_busy, clk, we |-> busy, "memory write while idle")

endmodule
`default_nettype wire

// File: bench/li_chao_segment_max_tree_tb.sv
// Testbench for li_chao_segment_max_tree: drives insert and query beats and checks
// each max_value against a line-tree predictor kept in the bench.
// Depends on the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module li_chao_segment_max_tree_tb;

	localparam int POINTS = 1024;
	localparam int SPAN = 1024;
	localparam bit OP_INSERT = 1'b0;
	localparam bit OP_QUERY = 1'b1;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               operation;
	logic signed [11:0] range_start;
	logic signed [11:0] range_end;
	logic signed [31:0] slope;
	logic signed [63:0] intercept;
	logic        [9:0]  point;
	logic               valid;
	logic        [62:0] max_value;

	li_chao_segment_max_tree #(.POINTS(POINTS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .range_start(range_start), .range_end(range_end),
		.slope(slope), .intercept(intercept), .point(point),
		.valid(valid), .max_value(max_value)
	);

	logic [63:0] tree_slope [1:2*SPAN-1];
	logic [63:0] tree_icpt [1:2*SPAN-1];
	logic [62:0] exp_max [0:255];
	int exp_wr;
	int exp_rd;
	int errors;
	int gap_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [63:0] eval_line(logic [63:0] s, logic [63:0] c, int unsigned x);
		logic [63:0] xx;
		xx = 64'(x);
		return s * xx + c;
	endfunction

	function automatic bit higher(logic [63:0] a, logic [63:0] b);
		return $signed(a) > $signed(b);
	endfunction

	function automatic void push_line(int unsigned u, int unsigned lo, int unsigned hi,
			logic [63:0] s, logic [63:0] c);
		int unsigned m;
		logic [63:0] t;
		forever begin
			m = (lo + hi) / 2;
			if (higher(eval_line(s, c, m), eval_line(tree_slope[u], tree_icpt[u], m))) begin
				t = tree_slope[u]; tree_slope[u] = s; s = t;
				t = tree_icpt[u]; tree_icpt[u] = c; c = t;
			end
			if (lo + 1 >= hi)
				return;
			if (higher(eval_line(s, c, lo), eval_line(tree_slope[u], tree_icpt[u], lo))) begin
				u = 2 * u; hi = m;
			end else if (higher(eval_line(s, c, hi),
					eval_line(tree_slope[u], tree_icpt[u], hi))) begin
				u = 2 * u + 1; lo = m;
			end else begin
				return;
			end
		end
	endfunction

	function automatic void insert_line(int a, int b, logic [31:0] s32, logic [63:0] c);
		int unsigned l, r, h;
		logic [63:0] s;
		s = {{32{s32[31]}}, s32};
		if (a < 0) a = 0;
		if (b > POINTS) b = POINTS;
		if (a >= b)
			return;
		l = a + SPAN;
		r = b + SPAN;
		for (h = 0; l < r; h++) begin
			if (l[0]) begin
				push_line(l, (l << h) - SPAN, ((l + 1) << h) - SPAN, s, c);
				l++;
			end
			if (r[0]) begin
				r--;
				push_line(r, (r << h) - SPAN, ((r + 1) << h) - SPAN, s, c);
			end
			l = l / 2;
			r = r / 2;
		end
	endfunction

	function automatic logic [62:0] max_at(int unsigned x);
		logic [63:0] best, v;
		int unsigned i;
		best = '0;
		if (x < POINTS) begin
			for (i = x + SPAN; i > 0; i = i / 2) begin
				v = eval_line(tree_slope[i], tree_icpt[i], x);
				if (higher(v, best))
					best = v;
			end
		end
		return best[62:0];
	endfunction

	task automatic send_beat(bit op, int a, int b, logic [31:0] s, logic [63:0] c,
			logic [9:0] x);
		int n;
		operation <= op;
		range_start <= a[11:0];
		range_end <= b[11:0];
		slope <= s;
		intercept <= c;
		point <= x;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (op == OP_QUERY) begin
			exp_max[exp_wr[7:0]] = max_at(x);
			exp_wr++;
		end else begin
			insert_line($signed(a[11:0]), $signed(b[11:0]), s, c);
		end
		if ($urandom_range(99) < gap_pct) begin
			n = $urandom_range(6, 1);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (exp_wr != exp_rd || busy)
			@(posedge clk);
	endtask

	task automatic query(logic [9:0] x);
		send_beat(OP_QUERY, $urandom_range(4095), $urandom_range(4095), $urandom,
			{$urandom, $urandom}, x);
	endtask

	task automatic insert(int a, int b, logic [31:0] s, logic [63:0] c);
		send_beat(OP_INSERT, a, b, s, c, 10'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (exp_wr == exp_rd) begin
				$display("%t unexpected beat: expected none, actual %0d", $realtime, max_value);
				errors++;
			end else begin
				if (max_value !== exp_max[exp_rd[7:0]]) begin
					$display("%t max_value mismatch: expected %0d, actual %0d",
						$realtime, exp_max[exp_rd[7:0]], max_value);
					errors++;
				end
				exp_rd++;
			end
		end
	end

	task automatic test_empty_tree();
		query(10'd0);
		query(10'd1023);
		query(10'd512);
		drain();
	endtask

	task automatic test_directed();
		insert(-1024, 1025, 32'sd3, 64'sd100);
		query(10'd0);
		query(10'd1023);
		insert(500, 500, 32'sd1000, 64'sd99999);
		insert(700, 600, 32'sd1000, 64'sd99999);
		insert(-1024, -1, 32'sd1000, 64'sd99999);
		insert(1024, 1025, 32'sd1000, 64'sd99999);
		query(10'd550);
		insert(0, 1, 32'h7fffffff, 64'h7fffffffffffffff);
		insert(1023, 1024, 32'h80000000, 64'h8000000000000000);
		insert(10, 300, -32'sd5, 64'sd5000);
		insert(200, 1000, 32'h7fffffff, 64'h7ffffffff0000000);
		insert(0, 1024, 32'h80000000, 64'h0000000100000000);
		query(10'd0);
		query(10'd10);
		query(10'd299);
		query(10'd700);
		query(10'd1023);
		insert(-5, 1025, 32'sd0, 64'h8000000000000000);
		query(10'd3);
		drain();
	endtask

	task automatic test_random(int count);
		int a, b, k;
		logic [31:0] s;
		logic [63:0] c;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 45) begin
				query(10'($urandom));
			end else begin
				if ($urandom_range(9) < 7) begin
					a = $urandom_range(1023);
					b = a + $urandom_range(64, 1);
					if (b > 1025) b = 1025;
				end else begin
					a = int'($urandom_range(2048)) - 1024;
					b = int'($urandom_range(2049)) - 1024;
				end
				case ($urandom_range(2))
					0: begin
						s = 32'($urandom_range(2000)) - 32'd1000;
						c = 64'($urandom_range(1000000));
					end
					1: begin
						s = $urandom;
						c = {$urandom, $urandom};
					end
					default: begin
						s = $urandom;
						c = {1'b0, 31'($urandom), $urandom};
					end
				endcase
				insert(a, b, s, c);
			end
		end
		drain();
	endtask

	initial begin
		errors = 0;
		gap_pct = 0;
		exp_wr = 0;
		exp_rd = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_INSERT;
		range_start = '0;
		range_end = '0;
		slope = '0;
		intercept = '0;
		point = '0;
		for (int i = 1; i < 2 * SPAN; i++) begin
			tree_slope[i] = '0;
			tree_icpt[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_tree();
		test_directed();
		gap_pct = 0;
		test_random(260);
		gap_pct = 53;
		test_random(260);
		gap_pct = 32;
		test_random(260);
		gap_pct = 0;
		test_random(240);
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
